FILE: hdl/psfc_pkg.sv
// ---------------------------------------------------------------------------
// psfc_pkg
// Shared types, codes and widths of the PCM sample float converter.
// ---------------------------------------------------------------------------
`default_nettype none

package psfc_pkg;

    localparam int FMT_W   = 3;
    localparam int CNT_W   = 6;
    localparam int BUF_W   = 40;
    localparam int FRAME_W = 32;
    localparam int CH_W    = 5;
    localparam int DATA_W  = 64;
    localparam int FLT_W   = 32;
    localparam int ADDR_W  = 40;
    localparam int BC_W    = 4;
    localparam int PROD_W  = 39;
    localparam int FULL_W  = 43;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFSIZE  = 2'd2;

    localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_I16 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_I24 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_I32 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_F32 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_F64 = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_U8,
        OP_RD_I16,
        OP_RD_I24,
        OP_RD_I32,
        OP_RD_F32,
        OP_RD_F64,
        OP_WR_U8,
        OP_WR_I16,
        OP_WR_I24,
        OP_WR_I32,
        OP_WR_F32,
        OP_WR_F64
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic              in_range;
        logic [BC_W-1:0]   nb;
        logic [DATA_W-1:0] data;
    } item_t;

    function automatic logic [BC_W-1:0] width_of(input logic [FMT_W-1:0] fmt);
        logic [BC_W-1:0] nb;
        case (fmt)
            FMT_U8:  nb = 4'd1;
            FMT_I16: nb = 4'd2;
            FMT_I24: nb = 4'd3;
            FMT_I32: nb = 4'd4;
            FMT_F32: nb = 4'd4;
            FMT_F64: nb = 4'd8;
            default: nb = 4'd1;
        endcase
        return nb;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/psfc_front.sv
// ---------------------------------------------------------------------------
// psfc_front
// Accepts beats, classifies them by format and kind, computes the byte
// address and the buffer range check.
// ---------------------------------------------------------------------------
`default_nettype none

module psfc_front (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire                             kind,
    input  wire  [psfc_pkg::FRAME_W-1:0]    frame_index,
    input  wire  [psfc_pkg::CH_W-1:0]       channel_index,
    input  wire  [psfc_pkg::DATA_W-1:0]     load_bits,
    input  wire  [psfc_pkg::FLT_W-1:0]      value_float,
    input  wire  [psfc_pkg::FMT_W-1:0]      sample_format,
    input  wire  [psfc_pkg::CNT_W-1:0]      channel_count,
    input  wire  [psfc_pkg::BUF_W-1:0]      buffer_size_bytes,
    output logic                            push_valid,
    input  wire                             push_ready,
    output psfc_pkg::item_t                 push_item
);

    logic                            f1_valid_reg;
    logic [psfc_pkg::PROD_W-1:0]     f1_prod_reg;
    psfc_pkg::op_t                   f1_op_reg;
    logic [psfc_pkg::BC_W-1:0]       f1_nb_reg;
    logic                            f1_fmt_ok_reg;
    logic [psfc_pkg::DATA_W-1:0]     f1_data_reg;

    logic [psfc_pkg::PROD_W-1:0]     f1_prod_next;
    psfc_pkg::op_t                   f1_op_next;
    logic [psfc_pkg::DATA_W-1:0]     f1_data_next;
    logic [psfc_pkg::FULL_W-1:0]     addr_full;
    logic [psfc_pkg::FULL_W-1:0]     end_full;
    logic                            ok;

    assign in_ready   = !f1_valid_reg || push_ready;
    assign push_valid = f1_valid_reg;

    assign f1_prod_next = psfc_pkg::PROD_W'(frame_index) * psfc_pkg::PROD_W'(channel_count)
                        + psfc_pkg::PROD_W'(channel_index);
    assign f1_data_next = kind ? {32'd0, value_float} : load_bits;

    always_comb
    begin
        unique case (sample_format)
            psfc_pkg::FMT_U8:  f1_op_next = kind ? psfc_pkg::OP_WR_U8  : psfc_pkg::OP_RD_U8;
            psfc_pkg::FMT_I16: f1_op_next = kind ? psfc_pkg::OP_WR_I16 : psfc_pkg::OP_RD_I16;
            psfc_pkg::FMT_I24: f1_op_next = kind ? psfc_pkg::OP_WR_I24 : psfc_pkg::OP_RD_I24;
            psfc_pkg::FMT_I32: f1_op_next = kind ? psfc_pkg::OP_WR_I32 : psfc_pkg::OP_RD_I32;
            psfc_pkg::FMT_F32: f1_op_next = kind ? psfc_pkg::OP_WR_F32 : psfc_pkg::OP_RD_F32;
            psfc_pkg::FMT_F64: f1_op_next = kind ? psfc_pkg::OP_WR_F64 : psfc_pkg::OP_RD_F64;
            default:           f1_op_next = psfc_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            f1_prod_reg   <= f1_prod_next;
            f1_op_reg     <= f1_op_next;
            f1_nb_reg     <= psfc_pkg::width_of(sample_format);
            f1_fmt_ok_reg <= (sample_format <= psfc_pkg::FMT_F64);
            f1_data_reg   <= f1_data_next;
        end
    end

    // address and range check of the held beat
    assign addr_full = psfc_pkg::FULL_W'(f1_prod_reg) * psfc_pkg::FULL_W'(f1_nb_reg);
    assign end_full  = addr_full + psfc_pkg::FULL_W'(f1_nb_reg);
    assign ok        = f1_fmt_ok_reg && (end_full <= psfc_pkg::FULL_W'(buffer_size_bytes));

    always_comb
    begin
        push_item.op       = ok ? f1_op_reg : psfc_pkg::OP_NONE;
        push_item.addr     = addr_full[psfc_pkg::ADDR_W-1:0];
        push_item.in_range = ok;
        push_item.nb       = f1_nb_reg;
        push_item.data     = f1_data_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/psfc_queue.sv
// ---------------------------------------------------------------------------
// psfc_queue
// Two-entry queue between the classify front and the conversion back.
// ---------------------------------------------------------------------------
`default_nettype none

module psfc_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push_valid,
    output logic             push_ready,
    input  psfc_pkg::item_t  push_item,
    output logic             pop_valid,
    input  wire              pop_ready,
    output psfc_pkg::item_t  pop_item
);

    psfc_pkg::item_t entry_reg [2];
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/psfc_back.sv
// ---------------------------------------------------------------------------
// psfc_back
// Conversion pipeline: align and normalize, then round, saturate and
// register the result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module psfc_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            pop_valid,
    output logic                           pop_ready,
    input  psfc_pkg::item_t                pop_item,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [psfc_pkg::ADDR_W-1:0]    byte_address,
    output logic                           in_range,
    output logic [psfc_pkg::FLT_W-1:0]     sample_float,
    output logic [psfc_pkg::DATA_W-1:0]    store_bits,
    output logic [psfc_pkg::BC_W-1:0]      byte_count
);

    typedef struct packed {
        psfc_pkg::op_t     op;
        logic [39:0]       addr;
        logic              in_range;
        logic [3:0]        nb;
        logic [31:0]       rbase;
        logic              rup;
        logic              wsign;
        logic              wbig;
        logic [31:0]       xint;
        logic              xst;
        logic [63:0]       wide;
    } stage_t;

    logic        b1_valid_reg;
    stage_t      b1_reg;
    stage_t      b1_next;
    logic        b1_en;
    logic        b2_en;

    logic        out_valid_reg;
    logic [39:0] addr_reg;
    logic        in_range_reg;
    logic [31:0] sample_float_reg;
    logic [63:0] store_bits_reg;
    logic [3:0]  byte_count_reg;
    logic [31:0] sample_float_next;
    logic [63:0] store_bits_next;

    // first stage signals
    logic [63:0]  d;
    logic [31:0]  s_al;
    logic [31:0]  r_mag;
    logic [4:0]   r_msb;
    logic [31:0]  r_nrm;
    logic [31:0]  int_base;
    logic         int_up;
    logic [31:0]  f64_base;
    logic         f64_up;
    logic [10:0]  e64;
    logic [5:0]   f64_sh;
    logic [116:0] f64_ext;
    logic         w_nan;
    logic [7:0]   we;
    logic [22:0]  wm;
    logic [6:0]   w_sh;
    logic [95:0]  w_ext;
    logic [4:0]   m_msb;
    logic [52:0]  m_nrm;
    logic [63:0]  f64_wide;

    // second stage signals
    logic [31:0]  i32_mag;
    logic [31:0]  i32_val;
    logic [15:0]  i16_mag;
    logic [15:0]  i16_val;
    logic [33:0]  y;
    logic [5:0]   y_msb;
    logic [3:0]   y_lsb;
    logic         y_rnd;
    logic         y_stk;
    logic         y_up;
    logic [34:0]  y_rounded;
    logic [9:0]   u8_q;
    logic [7:0]   u8_val;

    assign b2_en     = !out_valid_reg || out_ready;
    assign b1_en     = !b1_valid_reg || b2_en;
    assign pop_ready = b1_en;

    assign d = pop_item.data;

    // integer read: left-align to a 32-bit signed fraction
    always_comb
    begin
        case (pop_item.op)
            psfc_pkg::OP_RD_U8:  s_al = {~d[7], d[6:0], 24'd0};
            psfc_pkg::OP_RD_I16: s_al = {d[15:0], 16'd0};
            psfc_pkg::OP_RD_I24: s_al = {d[23:0], 8'd0};
            default:             s_al = d[31:0];
        endcase
        r_mag = s_al[31] ? (~s_al + 32'd1) : s_al;
        r_msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (r_mag[i])
            begin
                r_msb = 5'(i);
            end
        end
        r_nrm = r_mag << (5'd31 - r_msb);
        if (r_mag == 32'd0)
        begin
            int_base = 32'd0;
            int_up   = 1'b0;
        end
        else
        begin
            int_base = {s_al[31], 8'(r_msb) + 8'd96, r_nrm[30:8]};
            int_up   = r_nrm[7] & ((|r_nrm[6:0]) | r_nrm[8]);
        end
    end

    // double read: round to single, nearest even
    always_comb
    begin
        e64     = d[62:52];
        f64_sh  = (e64 < 11'd863) ? 6'd63 : 6'(11'd926 - e64);
        f64_ext = {1'b1, d[51:0], 64'd0} >> f64_sh;
        f64_up  = 1'b0;
        if (e64 == 11'h7ff)
        begin
            f64_base = (d[51:0] != 52'd0) ? {d[63], 8'hff, 1'b1, d[50:29]}
                                          : {d[63], 8'hff, 23'd0};
        end
        else if (e64 >= 11'd1151)
        begin
            f64_base = {d[63], 8'hff, 23'd0};
        end
        else if (e64 >= 11'd897)
        begin
            f64_base = {d[63], 8'(e64 - 11'd896), d[51:29]};
            f64_up   = d[28] & ((|d[27:0]) | d[29]);
        end
        else if (e64 == 11'd0)
        begin
            f64_base = {d[63], 31'd0};
        end
        else
        begin
            f64_base = {d[63], 8'd0, f64_ext[86:64]};
            f64_up   = f64_ext[63] & ((|f64_ext[62:0]) | f64_ext[64]);
        end
    end

    // float write: magnitude as a 32-bit fraction, and widening to double
    always_comb
    begin
        we    = d[30:23];
        wm    = d[22:0];
        w_nan = (we == 8'hff) && (wm != 23'd0);
        w_sh  = (we < 8'd63) ? 7'd63 : 7'(8'd126 - we);
        w_ext = {(we != 8'd0), wm, 8'd0, 64'd0} >> w_sh;
        m_msb = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (wm[i])
            begin
                m_msb = 5'(i);
            end
        end
        m_nrm = 53'(wm) << (6'd52 - 6'(m_msb));
        if (we == 8'hff)
        begin
            f64_wide = w_nan ? {d[31], 11'h7ff, 1'b1, wm[21:0], 29'd0}
                             : {d[31], 11'h7ff, 52'd0};
        end
        else if (we == 8'd0)
        begin
            f64_wide = (wm == 23'd0) ? {d[31], 63'd0}
                                     : {d[31], 11'(m_msb) + 11'd874, m_nrm[51:0]};
        end
        else
        begin
            f64_wide = {d[31], 11'(we) + 11'd896, wm, 29'd0};
        end
    end

    always_comb
    begin
        b1_next.op       = pop_item.op;
        b1_next.addr     = pop_item.addr;
        b1_next.in_range = pop_item.in_range;
        b1_next.nb       = pop_item.nb;
        b1_next.wsign    = !w_nan && d[31];
        b1_next.wbig     = !w_nan && (we >= 8'd127);
        b1_next.xint     = w_nan ? 32'd0 : w_ext[95:64];
        b1_next.xst      = !w_nan && (|w_ext[63:0]);
        b1_next.wide     = (pop_item.op == psfc_pkg::OP_WR_F64) ? f64_wide : {32'd0, d[31:0]};
        case (pop_item.op)
            psfc_pkg::OP_RD_F32:
            begin
                b1_next.rbase = d[31:0];
                b1_next.rup   = 1'b0;
            end
            psfc_pkg::OP_RD_F64:
            begin
                b1_next.rbase = f64_base;
                b1_next.rup   = f64_up;
            end
            default:
            begin
                b1_next.rbase = int_base;
                b1_next.rup   = int_up;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_en)
            begin
                b1_valid_reg <= pop_valid;
            end
            if (b2_en)
            begin
                out_valid_reg <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && b1_en)
        begin
            b1_reg <= b1_next;
        end
        if (b1_valid_reg && b2_en)
        begin
            addr_reg         <= b1_reg.addr;
            in_range_reg     <= b1_reg.in_range;
            byte_count_reg   <= b1_reg.nb;
            sample_float_reg <= sample_float_next;
            store_bits_reg   <= store_bits_next;
        end
    end

    // integer write: truncate toward zero and saturate
    always_comb
    begin
        i32_mag = {1'b0, b1_reg.xint[31:1]};
        if (b1_reg.wbig)
        begin
            i32_val = b1_reg.wsign ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        else
        begin
            i32_val = b1_reg.wsign ? (~i32_mag + 32'd1) : i32_mag;
        end
        i16_mag = {1'b0, b1_reg.xint[31:17]};
        if (b1_reg.wbig)
        begin
            i16_val = b1_reg.wsign ? 16'h8000 : 16'h7fff;
        end
        else
        begin
            i16_val = b1_reg.wsign ? (~i16_mag + 16'd1) : i16_mag;
        end
    end

    // unsigned 8-bit write: round x + 1 to single, then scale and truncate
    always_comb
    begin
        if (b1_reg.wsign)
        begin
            y = 34'h1_0000_0000 - 34'(b1_reg.xint) - 34'(b1_reg.xst);
        end
        else
        begin
            y = 34'h1_0000_0000 + 34'(b1_reg.xint);
        end
        y_msb = 6'd0;
        for (int i = 0; i < 34; i++)
        begin
            if (y[i])
            begin
                y_msb = 6'(i);
            end
        end
        y_lsb     = (y_msb < 6'd25) ? 4'd2 : 4'(y_msb - 6'd23);
        y_rnd     = y[y_lsb - 4'd1];
        y_stk     = (|(y & ((34'd1 << (y_lsb - 4'd1)) - 34'd1))) | b1_reg.xst;
        y_up      = y_rnd & (y_stk | y[y_lsb]);
        y_rounded = 35'((35'(y) >> y_lsb) + 35'(y_up)) << y_lsb;
        u8_q      = y_rounded[34:25];
        if (b1_reg.wbig)
        begin
            u8_val = b1_reg.wsign ? 8'd0 : 8'd255;
        end
        else if (y_msb < 6'd25)
        begin
            u8_val = 8'd0;
        end
        else if (u8_q > 10'd255)
        begin
            u8_val = 8'd255;
        end
        else
        begin
            u8_val = u8_q[7:0];
        end
    end

    always_comb
    begin
        sample_float_next = 32'd0;
        store_bits_next   = 64'd0;
        case (b1_reg.op) inside
            psfc_pkg::OP_RD_U8,
            psfc_pkg::OP_RD_I16,
            psfc_pkg::OP_RD_I24,
            psfc_pkg::OP_RD_I32,
            psfc_pkg::OP_RD_F32,
            psfc_pkg::OP_RD_F64: sample_float_next = b1_reg.rbase + 32'(b1_reg.rup);
            psfc_pkg::OP_WR_U8:  store_bits_next = 64'(u8_val);
            psfc_pkg::OP_WR_I16: store_bits_next = 64'(i16_val);
            psfc_pkg::OP_WR_I24: store_bits_next = 64'(i32_val[31:8]);
            psfc_pkg::OP_WR_I32: store_bits_next = 64'(i32_val);
            psfc_pkg::OP_WR_F32,
            psfc_pkg::OP_WR_F64: store_bits_next = b1_reg.wide;
            default:
            begin
                sample_float_next = 32'd0;
                store_bits_next   = 64'd0;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign byte_address = addr_reg;
    assign in_range     = in_range_reg;
    assign sample_float = sample_float_reg;
    assign store_bits   = store_bits_reg;
    assign byte_count   = byte_count_reg;

endmodule

`default_nettype wire

FILE: hdl/pcm_sample_float_converter.sv
// ---------------------------------------------------------------------------
// pcm_sample_float_converter
// Address, range check and float conversion of interleaved PCM samples.
//
//   channel   handshake             payload
//   in        in_valid / in_ready   kind, frame_index, channel_index,
//                                   load_bits, value_float
//   out       out_valid / out_ready byte_address, in_range, sample_float,
//                                   store_bits, byte_count
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one beat per clock while out_ready is high; an in beat passes the address stage,
// queue, align stage and round stage in that order before it leaves as an out beat
// the two-entry queue lets the front keep taking beats while out is stalled, until the queue is full
// rst_n clears the pipeline and loads the register defaults; cfg is always ready
// ---------------------------------------------------------------------------
`default_nettype none

module pcm_sample_float_converter (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                kind,
    input  wire  [psfc_pkg::FRAME_W-1:0]       frame_index,
    input  wire  [psfc_pkg::CH_W-1:0]          channel_index,
    input  wire  [psfc_pkg::DATA_W-1:0]        load_bits,
    input  wire  [psfc_pkg::FLT_W-1:0]         value_float,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [psfc_pkg::ADDR_W-1:0]        byte_address,
    output logic                               in_range,
    output logic [psfc_pkg::FLT_W-1:0]         sample_float,
    output logic [psfc_pkg::DATA_W-1:0]        store_bits,
    output logic [psfc_pkg::BC_W-1:0]          byte_count,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [psfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [psfc_pkg::BUF_W-1:0]         cfg_data
);

    logic [psfc_pkg::FMT_W-1:0] sample_format_reg;
    logic [psfc_pkg::CNT_W-1:0] channel_count_reg;
    logic [psfc_pkg::BUF_W-1:0] buffer_size_reg;

    logic            push_valid;
    logic            push_ready;
    psfc_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    psfc_pkg::item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_format_reg <= psfc_pkg::FMT_I16;
            channel_count_reg <= 6'd2;
            buffer_size_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                psfc_pkg::CFG_FORMAT:   sample_format_reg <= cfg_data[psfc_pkg::FMT_W-1:0];
                psfc_pkg::CFG_CHANNELS: channel_count_reg <= cfg_data[psfc_pkg::CNT_W-1:0];
                psfc_pkg::CFG_BUFSIZE:  buffer_size_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    psfc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .frame_index       (frame_index),
        .channel_index     (channel_index),
        .load_bits         (load_bits),
        .value_float       (value_float),
        .sample_format     (sample_format_reg),
        .channel_count     (channel_count_reg),
        .buffer_size_bytes (buffer_size_reg),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_item         (push_item)
    );

    psfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    psfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_address (byte_address),
        .in_range     (in_range),
        .sample_float (sample_float),
        .store_bits   (store_bits),
        .byte_count   (byte_count)
    );

endmodule

`default_nettype wire
